// ===== sv/lapf_pkg.sv =====
package lapf_pkg;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 11'd1024;

    localparam int SUM_W = 13;
    localparam int MAG_W = 12;
    localparam logic [MAG_W-1:0] DIV3_MUL = 12'd2731;
    localparam int DIV3_SHIFT = 13;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef struct packed {
        logic [7:0] ch2;
        logic [7:0] ch1;
        logic [7:0] ch0;
    } pixel_t;

    localparam int PIX_W = $bits(pixel_t);

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } tag_t;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] value;
        logic       saturated;
        logic       last;
    } result_t;

endpackage

// ===== sv/lapf_ram.sv =====
module lapf_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== sv/lapf_kernel.sv =====
module lapf_kernel
    import lapf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    color_mode,
    input  logic    tap_valid,
    input  tag_t    tap_tag,
    input  pixel_t  above,
    input  pixel_t  left,
    input  pixel_t  centre,
    input  pixel_t  right,
    input  pixel_t  below,
    output logic    res_valid,
    output result_t res
);

    function automatic logic signed [10:0] chan_sum(
        input logic [7:0] a,
        input logic [7:0] l,
        input logic [7:0] c,
        input logic [7:0] r,
        input logic [7:0] b
    );
        logic [10:0] pos;
        pos = 11'(a) + 11'(l) + 11'(r) + 11'(b);
        return $signed(pos - {1'b0, c, 2'b00});
    endfunction

    logic signed [10:0]    sum_ch0;
    logic signed [10:0]    sum_ch1;
    logic signed [10:0]    sum_ch2;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;
    tag_t                  tag_reg;
    logic                  valid_reg;
    logic [MAG_W-1:0]      mag;
    logic [2*MAG_W-1:0]    prod;
    logic [MAG_W-1:0]      mag_final;
    logic                  sat;

    always_comb
    begin
        sum_ch0 = chan_sum(above.ch0, left.ch0, centre.ch0, right.ch0, below.ch0);
        sum_ch1 = chan_sum(above.ch1, left.ch1, centre.ch1, right.ch1, below.ch1);
        sum_ch2 = chan_sum(above.ch2, left.ch2, centre.ch2, right.ch2, below.ch2);
        sum_next = {{2{sum_ch0[10]}}, sum_ch0};
        if (color_mode)
        begin
            sum_next = {{2{sum_ch0[10]}}, sum_ch0} + {{2{sum_ch1[10]}}, sum_ch1}
                     + {{2{sum_ch2[10]}}, sum_ch2};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        tag_reg <= tap_tag;
    end

    always_comb
    begin
        mag = sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
        prod = (2*MAG_W)'(mag) * (2*MAG_W)'(DIV3_MUL);
        mag_final = color_mode ? MAG_W'(prod >> DIV3_SHIFT) : mag;
        sat = mag_final > MAG_W'(255);
        res.row = tag_reg.row;
        res.col = tag_reg.col;
        res.value = sat ? 8'hFF : mag_final[7:0];
        res.saturated = sat;
        res.last = tag_reg.last;
    end

    assign res_valid = valid_reg;

endmodule

// ===== sv/lapf_fifo.sv =====
module lapf_fifo
    import lapf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  result_t               push_data,
    input  logic                  pop_stall,
    output logic                  pop_valid,
    output result_t               pop_data,
    output logic [FIFO_CNT_W-1:0] count
);

    result_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    pop;

    assign pop = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_valid = count_reg != '0;
    assign pop_data = entry_reg[rd_ptr_reg];
    assign count = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
        else $error("Result queue written while full.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("Result queue count out of range.");

endmodule

// ===== sv/laplacian_3x3_mirror_filter.sv =====
// Four-neighbour 3x3 Laplacian filter with mirrored borders on a raster pixel stream.
// The input channel carries one request per pixel (cmd pixel) or a drain request
// (cmd drain); a request is taken when item_valid is high and item_stall is low.
// Each pixel of row r+1 releases the result for the pixel above it, and once the
// whole frame has arrived, one drain request per column releases the last row.
// Results leave on the result channel, taken when result_valid is high and
// result_stall is low; frame_last marks the bottom-right pixel.
// Two line memories of MAX_WIDTH entries hold the previous rows; while item_stall
// is low, the block sustains one request per clock.
// A released result is registered after the memory read and in the kernel, then queued.
// A four-entry result queue decouples the sides: item_stall rises only when the
// queue and the two pipeline stages together could not take one more result.
// Configuration writes are always taken; those to width, height or mode restart the
// frame; they are meant to arrive only while no request is in flight.
// Reset clears the position counters and the pipeline, sets width and height to
// 1024 and selects gray mode; the line memories need no clearing.
module laplacian_3x3_mirror_filter
    import lapf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  cmd,
    input  logic [7:0]            pixel_ch0,
    input  logic [7:0]            pixel_ch1,
    input  logic [7:0]            pixel_ch2,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [9:0]            out_row,
    output logic [9:0]            out_col,
    output logic [7:0]            out_value,
    output logic                  saturated,
    output logic                  frame_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int CMP_W = COL_W + 1;
    localparam int FLT_W = FIFO_CNT_W + 1;

    function automatic logic [13:0] clamp_dim(
        input logic [CFG_DATA_W-1:0] v,
        input int unsigned           max_v
    );
        logic [13:0] r;
        if (v < CFG_DATA_W'(2))
        begin
            r = 14'd2;
        end
        else if (32'(v) > max_v)
        begin
            r = 14'(max_v);
        end
        else
        begin
            r = 14'(v);
        end
        return r;
    endfunction

    logic [EW-1:0]    w_eff_reg;
    logic [EW-1:0]    w_eff_next;
    logic [RW-1:0]    h_eff_reg;
    logic [RW-1:0]    h_eff_next;
    logic             mode_reg;
    logic             mode_next;
    logic [RW-1:0]    row_reg;
    logic [RW-1:0]    row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;

    logic             cfg_write;
    logic             accept;
    logic             frame_done;
    logic             pix_take;
    logic             drain_take;
    logic             emit;
    logic             col_end;
    logic [COL_W-1:0] right_col;
    pixel_t           px;

    logic             v1_reg;
    logic             par1_reg;
    logic             first_row1_reg;
    logic             drain1_reg;
    logic             col_zero1_reg;
    pixel_t           px1_reg;
    tag_t             tag1_reg;
    tag_t             tag1_next;
    pixel_t           prev_centre_reg;
    pixel_t           prev_centre_next;

    pixel_t           rd_a0;
    pixel_t           rd_b0;
    pixel_t           rd_a1;
    pixel_t           rd_b1;
    pixel_t           tap_above;
    pixel_t           tap_left;
    pixel_t           tap_centre;
    pixel_t           tap_right;
    pixel_t           tap_below;

    logic                  res_valid;
    result_t               res;
    result_t               head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FLT_W-1:0]      in_flight;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_MODE});

    assign in_flight = FLT_W'(v1_reg) + FLT_W'(res_valid) + FLT_W'(fifo_count);
    assign item_stall = in_flight >= FLT_W'(FIFO_DEPTH);
    assign accept = item_valid && !item_stall;

    assign px = '{ch2: pixel_ch2, ch1: pixel_ch1, ch0: pixel_ch0};

    always_comb
    begin
        frame_done = row_reg == h_eff_reg;
        pix_take = accept && !cfg_write && cmd == CMD_PIXEL && !frame_done;
        drain_take = accept && !cfg_write && cmd == CMD_DRAIN && frame_done;
        emit = (pix_take && row_reg != '0) || drain_take;
        col_end = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(w_eff_reg);
        right_col = col_end ? col_reg - COL_W'(1) : col_reg + COL_W'(1);
        tag1_next.row = 10'(row_reg - RW'(1));
        tag1_next.col = 10'(col_reg);
        tag1_next.last = drain_take && col_end;
    end

    always_comb
    begin
        w_eff_next = w_eff_reg;
        h_eff_next = h_eff_reg;
        mode_next = mode_reg;
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_WIDTH:  w_eff_next = EW'(clamp_dim(cfg_data, MAX_WIDTH));
                REG_HEIGHT: h_eff_next = RW'(clamp_dim(cfg_data, MAX_HEIGHT));
                REG_MODE:   mode_next = cfg_data[0];
                default:    mode_next = mode_reg;
            endcase
            row_next = '0;
            col_next = '0;
        end
        else if (pix_take)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        else if (drain_take)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg <= EW'(clamp_dim(DIM_RESET, MAX_WIDTH));
            h_eff_reg <= RW'(clamp_dim(DIM_RESET, MAX_HEIGHT));
            mode_reg <= 1'b0;
            row_reg <= '0;
            col_reg <= '0;
            v1_reg <= 1'b0;
        end
        else
        begin
            w_eff_reg <= w_eff_next;
            h_eff_reg <= h_eff_next;
            mode_reg <= mode_next;
            row_reg <= row_next;
            col_reg <= col_next;
            v1_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        par1_reg <= row_reg[0];
        first_row1_reg <= pix_take && row_reg == RW'(1);
        drain1_reg <= drain_take;
        col_zero1_reg <= col_reg == '0;
        px1_reg <= px;
        tag1_reg <= tag1_next;
        prev_centre_reg <= prev_centre_next;
    end

    lapf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line0 (
        .clk     (clk),
        .we      (pix_take && !row_reg[0]),
        .waddr   (col_reg),
        .wdata   (px),
        .raddr_a (col_reg),
        .rdata_a (rd_a0),
        .raddr_b (right_col),
        .rdata_b (rd_b0)
    );

    lapf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line1 (
        .clk     (clk),
        .we      (pix_take && row_reg[0]),
        .waddr   (col_reg),
        .wdata   (px),
        .raddr_a (col_reg),
        .rdata_a (rd_a1),
        .raddr_b (right_col),
        .rdata_b (rd_b1)
    );

    // The memory of the incoming row's parity holds the row above the centre row.
    always_comb
    begin
        tap_centre = par1_reg ? rd_a0 : rd_a1;
        tap_right = par1_reg ? rd_b0 : rd_b1;
        tap_above = first_row1_reg ? px1_reg : (par1_reg ? rd_a1 : rd_a0);
        tap_below = drain1_reg ? tap_above : px1_reg;
        tap_left = col_zero1_reg ? tap_right : prev_centre_reg;
        prev_centre_next = v1_reg ? tap_centre : prev_centre_reg;
    end

    lapf_kernel u_kernel (
        .clk        (clk),
        .rst_n      (rst_n),
        .color_mode (mode_reg),
        .tap_valid  (v1_reg),
        .tap_tag    (tag1_reg),
        .above      (tap_above),
        .left       (tap_left),
        .centre     (tap_centre),
        .right      (tap_right),
        .below      (tap_below),
        .res_valid  (res_valid),
        .res        (res)
    );

    lapf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop_stall (result_stall),
        .pop_valid (result_valid),
        .pop_data  (head),
        .count     (fifo_count)
    );

    assign out_row = head.row;
    assign out_col = head.col;
    assign out_value = head.value;
    assign saturated = head.saturated;
    assign frame_last = head.last;

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_eff_reg)
        else $error("Input row beyond the frame height.");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(col_reg) < CMP_W'(w_eff_reg))
        else $error("Input column beyond the frame width.");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_take && col_end) |=> (row_reg == '0 && col_reg == '0 && v1_reg))
        else $error("Frame did not restart after the last drain request.");

endmodule
